@@ hdl/tlt_pkg.sv @@
package tlt_pkg;

    localparam int MatchCountDefault   = 6;
    localparam int TimeoutCountDefault = 15;
    localparam int QueueDepth          = 2;

    localparam logic [1:0] CMD_WAKE    = 2'd0;
    localparam logic [1:0] CMD_SAMPLE  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    localparam logic [3:0] CLS_NONE  = 4'd0;
    localparam logic [3:0] CLS_NEG_X = 4'd1;
    localparam logic [3:0] CLS_POS_X = 4'd2;
    localparam logic [3:0] CLS_NEG_Y = 4'd4;
    localparam logic [3:0] CLS_POS_Y = 4'd8;

    localparam logic [2:0] REG_TILT_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_KEY_NEG_X      = 3'd1;
    localparam logic [2:0] REG_KEY_POS_X      = 3'd2;
    localparam logic [2:0] REG_KEY_NEG_Y      = 3'd3;
    localparam logic [2:0] REG_KEY_POS_Y      = 3'd4;

    localparam logic [1:0] KEY_NORTH = 2'd0;
    localparam logic [1:0] KEY_SOUTH = 2'd1;
    localparam logic [1:0] KEY_EAST  = 2'd2;
    localparam logic [1:0] KEY_WEST  = 2'd3;

    localparam logic [15:0] FACTOR_WOKEN = 16'd200;
    localparam logic [15:0] FACTOR_IDLE  = 16'd400;
    localparam logic [7:0]  CFG_BASE     = 8'hC0;
    localparam logic [3:0]  DIR_ALL      = 4'hF;
    localparam logic [3:0]  COUNT_MAX    = 4'd15;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] cls;
        logic [1:0] key;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t data;
    } queue_out_t;

    function automatic logic [1:0] key_to_orientation(input logic [1:0] key);
        logic [1:0] orient;
        case (key)
            KEY_NORTH: orient = 2'd3;
            KEY_WEST:  orient = 2'd1;
            KEY_EAST:  orient = 2'd2;
            default:   orient = 2'd0;
        endcase
        return orient;
    endfunction

endpackage

@@ hdl/tlt_front.sv @@
module tlt_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [6:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    output logic               push_valid,
    input  logic               push_ready,
    output tlt_pkg::item_t     push_data
);

    logic [6:0] threshold_reg;
    logic [1:0] key_neg_x_reg;
    logic [1:0] key_pos_x_reg;
    logic [1:0] key_neg_y_reg;
    logic [1:0] key_pos_y_reg;
    logic       woken_reg;
    logic       woken_next;

    logic [15:0]        th;
    logic signed [17:0] ths;
    logic signed [17:0] xs;
    logic signed [17:0] ys;
    logic signed [17:0] ax;
    logic signed [17:0] ay;
    logic [3:0]         cls;
    logic [1:0]         key;
    logic               accept;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign accept     = s_valid && push_ready;

    always_comb begin
        th  = 16'({9'd0, threshold_reg} *
                  (woken_reg ? tlt_pkg::FACTOR_WOKEN : tlt_pkg::FACTOR_IDLE));
        ths = signed'({2'b00, th});
        xs  = 18'(s_accel_x);
        ys  = 18'(s_accel_y);
        ax  = (xs < 0) ? -xs : xs;
        ay  = (ys < 0) ? -ys : ys;
        cls = tlt_pkg::CLS_NONE;
        key = tlt_pkg::KEY_NORTH;
        if ((xs < -ths) && (ax > ay)) begin
            cls = tlt_pkg::CLS_NEG_X;
            key = key_neg_x_reg;
        end else if ((xs > ths) && (ax > ay)) begin
            cls = tlt_pkg::CLS_POS_X;
            key = key_pos_x_reg;
        end else if ((ys < -ths) && (ay > ax)) begin
            cls = tlt_pkg::CLS_NEG_Y;
            key = key_neg_y_reg;
        end else if ((ys > ths) && (ay > ax)) begin
            cls = tlt_pkg::CLS_POS_Y;
            key = key_pos_y_reg;
        end
        if (s_cmd != tlt_pkg::CMD_SAMPLE) begin
            cls = tlt_pkg::CLS_NONE;
        end
    end

    assign push_data = '{cmd: s_cmd, cls: cls, key: key};

    always_comb begin
        woken_next = woken_reg;
        if (accept) begin
            case (s_cmd)
                tlt_pkg::CMD_WAKE:    woken_next = 1'b1;
                tlt_pkg::CMD_RESTART: woken_next = 1'b0;
                default:              woken_next = woken_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= 7'd7;
            key_neg_x_reg <= tlt_pkg::KEY_SOUTH;
            key_pos_x_reg <= tlt_pkg::KEY_NORTH;
            key_neg_y_reg <= tlt_pkg::KEY_WEST;
            key_pos_y_reg <= tlt_pkg::KEY_EAST;
            woken_reg     <= 1'b0;
        end else begin
            woken_reg <= woken_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    tlt_pkg::REG_TILT_THRESHOLD: threshold_reg <= cfg_wdata;
                    tlt_pkg::REG_KEY_NEG_X:      key_neg_x_reg <= cfg_wdata[1:0];
                    tlt_pkg::REG_KEY_POS_X:      key_pos_x_reg <= cfg_wdata[1:0];
                    tlt_pkg::REG_KEY_NEG_Y:      key_neg_y_reg <= cfg_wdata[1:0];
                    tlt_pkg::REG_KEY_POS_Y:      key_pos_y_reg <= cfg_wdata[1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ hdl/tlt_queue.sv @@
module tlt_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  tlt_pkg::item_t       push_data,
    output tlt_pkg::queue_out_t  pop,
    input  logic                 pop_ready
);

    localparam int Depth  = tlt_pkg::QueueDepth;
    localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountW = $clog2(Depth + 1);

    tlt_pkg::item_t    entry_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [CountW-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != CountW'(Depth));
    assign pop.valid  = (count_reg != '0);
    assign pop.data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop.valid && pop_ready;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ hdl/tlt_back.sv @@
module tlt_back #(
    parameter int MATCH_COUNT   = tlt_pkg::MatchCountDefault,
    parameter int TIMEOUT_COUNT = tlt_pkg::TimeoutCountDefault
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tlt_pkg::queue_out_t pop,
    output logic                pop_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_tilt_class,
    output logic                m_key_valid,
    output logic [1:0]          m_key_code,
    output logic [1:0]          m_orientation_now,
    output logic                m_done_res,
    output logic                m_poll_again,
    output logic [7:0]          m_int_config_word
);

    localparam logic [3:0] MatchLimit   = 4'(MATCH_COUNT);
    localparam logic [3:0] TimeoutLimit = 4'(TIMEOUT_COUNT);

    logic [3:0] last_class_reg, last_class_next;
    logic [3:0] repeat_reg, repeat_next;
    logic [3:0] timeout_reg, timeout_next;
    logic [1:0] orient_reg, orient_next;
    logic       m_valid_reg;

    logic [3:0] cls_reg, cls_next;
    logic       kvalid_reg, kvalid_next;
    logic [1:0] kcode_reg, kcode_next;
    logic       done_reg, done_next;
    logic       poll_reg, poll_next;
    logic [7:0] word_reg, word_next;

    logic       take;

    assign pop_ready = !m_valid_reg || m_ready;
    assign take      = pop.valid && pop_ready;

    always_comb begin
        last_class_next = last_class_reg;
        repeat_next     = repeat_reg;
        timeout_next    = timeout_reg;
        orient_next     = orient_reg;
        cls_next        = tlt_pkg::CLS_NONE;
        kvalid_next     = 1'b0;
        kcode_next      = tlt_pkg::KEY_NORTH;
        done_next       = 1'b0;
        poll_next       = 1'b0;
        word_next       = 8'd0;
        case (pop.data.cmd)
            tlt_pkg::CMD_WAKE: begin
                last_class_next = tlt_pkg::CLS_NONE;
                repeat_next     = 4'd0;
                timeout_next    = 4'd0;
                poll_next       = 1'b1;
            end
            tlt_pkg::CMD_RESTART: begin
                poll_next = 1'b1;
            end
            tlt_pkg::CMD_SAMPLE: begin
                cls_next = pop.data.cls;
                if (pop.data.cls == last_class_reg) begin
                    if (repeat_reg < tlt_pkg::COUNT_MAX) begin
                        repeat_next = repeat_reg + 4'd1;
                    end
                end else begin
                    last_class_next = pop.data.cls;
                    repeat_next     = 4'd0;
                end
                if (repeat_next >= MatchLimit) begin
                    if (pop.data.cls != tlt_pkg::CLS_NONE) begin
                        kvalid_next = 1'b1;
                        kcode_next  = pop.data.key;
                        orient_next = tlt_pkg::key_to_orientation(pop.data.key);
                    end
                    done_next = 1'b1;
                    word_next = tlt_pkg::CFG_BASE | {4'd0, tlt_pkg::DIR_ALL & ~pop.data.cls};
                end else begin
                    if (timeout_reg < tlt_pkg::COUNT_MAX) begin
                        timeout_next = timeout_reg + 4'd1;
                    end
                    if (timeout_next >= TimeoutLimit) begin
                        done_next = 1'b1;
                        word_next = tlt_pkg::CFG_BASE | {4'd0, tlt_pkg::DIR_ALL};
                    end else begin
                        poll_next = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_class_reg <= tlt_pkg::CLS_NONE;
            repeat_reg     <= 4'd0;
            timeout_reg    <= 4'd0;
            orient_reg     <= 2'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (take) begin
                last_class_reg <= last_class_next;
                repeat_reg     <= repeat_next;
                timeout_reg    <= timeout_next;
                orient_reg     <= orient_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            cls_reg    <= cls_next;
            kvalid_reg <= kvalid_next;
            kcode_reg  <= kcode_next;
            done_reg   <= done_next;
            poll_reg   <= poll_next;
            word_reg   <= word_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_tilt_class      = cls_reg;
    assign m_key_valid       = kvalid_reg;
    assign m_key_code        = kcode_reg;
    assign m_orientation_now = orient_reg;
    assign m_done_res        = done_reg;
    assign m_poll_again      = poll_reg;
    assign m_int_config_word = word_reg;

endmodule

@@ hdl/tilt_orientation_qualifier_core.sv @@
// Channel   Direction  Handshake           Payload
// config    in         cfg_wr_en           cfg_index, cfg_wdata
// s_        in         s_valid / s_ready   s_cmd, s_accel_x, s_accel_y
// m_        out        m_valid / m_ready   tilt_class .. int_config_word
//
// One item per cycle sustained while the output is not stalled; an accepted item is
// written into the queue and from there registered into the output register.
// The front stage classifies on entry; a two-entry queue feeds the counter stage.
// Reset is synchronous and active low and restores the default register values.
// The input stalls only when the queue is full behind a stalled output register.
module tilt_orientation_qualifier_core #(
    parameter int MATCH_COUNT   = tlt_pkg::MatchCountDefault,
    parameter int TIMEOUT_COUNT = tlt_pkg::TimeoutCountDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [6:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_tilt_class,
    output logic               m_key_valid,
    output logic [1:0]         m_key_code,
    output logic [1:0]         m_orientation_now,
    output logic               m_done_res,
    output logic               m_poll_again,
    output logic [7:0]         m_int_config_word
);

    logic                push_valid;
    logic                push_ready;
    tlt_pkg::item_t      push_data;
    tlt_pkg::queue_out_t pop;
    logic                pop_ready;

    tlt_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_accel_x  (s_accel_x),
        .s_accel_y  (s_accel_y),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tlt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop        (pop),
        .pop_ready  (pop_ready)
    );

    tlt_back #(
        .MATCH_COUNT   (MATCH_COUNT),
        .TIMEOUT_COUNT (TIMEOUT_COUNT)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .pop               (pop),
        .pop_ready         (pop_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_tilt_class      (m_tilt_class),
        .m_key_valid       (m_key_valid),
        .m_key_code        (m_key_code),
        .m_orientation_now (m_orientation_now),
        .m_done_res        (m_done_res),
        .m_poll_again      (m_poll_again),
        .m_int_config_word (m_int_config_word)
    );

endmodule

@@ test/tilt_orientation_qualifier_checker.sv @@
`timescale 1ns / 1ps

module tilt_orientation_qualifier_checker #(
    parameter int MATCH_COUNT   = tlt_pkg::MatchCountDefault,
    parameter int TIMEOUT_COUNT = tlt_pkg::TimeoutCountDefault
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [6:0]         cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [3:0]         m_tilt_class,
    input  logic               m_key_valid,
    input  logic [1:0]         m_key_code,
    input  logic [1:0]         m_orientation_now,
    input  logic               m_done_res,
    input  logic               m_poll_again,
    input  logic [7:0]         m_int_config_word,
    output int                 mismatch_count,
    output int                 pending_count
);

    typedef struct packed {
        logic [3:0] tilt_class;
        logic       key_valid;
        logic [1:0] key_code;
        logic [1:0] orientation;
        logic       done;
        logic       poll;
        logic [7:0] cfg_word;
    } tilt_report_t;

    logic [6:0] thr_unit;
    logic [1:0] key_neg_x;
    logic [1:0] key_pos_x;
    logic [1:0] key_neg_y;
    logic [1:0] key_pos_y;

    logic [3:0] prev_class;
    logic [3:0] run_len;
    logic [3:0] sample_age;
    logic       woken;
    logic [1:0] orient;

    tilt_report_t tilt_reports_q[$];

    function automatic logic [1:0] orientation_of(input logic [1:0] key);
        case (key)
            tlt_pkg::KEY_NORTH: return 2'd3;
            tlt_pkg::KEY_WEST:  return 2'd1;
            tlt_pkg::KEY_EAST:  return 2'd2;
            default:            return 2'd0;
        endcase
    endfunction

    task automatic restore_defaults();
        thr_unit   = 7'd7;
        key_neg_x  = tlt_pkg::KEY_SOUTH;
        key_pos_x  = tlt_pkg::KEY_NORTH;
        key_neg_y  = tlt_pkg::KEY_WEST;
        key_pos_y  = tlt_pkg::KEY_EAST;
        prev_class = tlt_pkg::CLS_NONE;
        run_len    = '0;
        sample_age = '0;
        woken      = 1'b0;
        orient     = 2'd0;
    endtask

    task automatic qualify_item(input logic [1:0] cmd, input logic signed [15:0] x,
                                input logic signed [15:0] y);
        tilt_report_t r;
        int sx, sy, ax, ay, th;
        logic [3:0] cls;
        logic [1:0] key;
        r   = '0;
        cls = tlt_pkg::CLS_NONE;
        key = tlt_pkg::KEY_NORTH;
        case (cmd)
            tlt_pkg::CMD_WAKE: begin
                sample_age = '0;
                run_len    = '0;
                prev_class = tlt_pkg::CLS_NONE;
                woken      = 1'b1;
                r.poll     = 1'b1;
            end
            tlt_pkg::CMD_RESTART: begin
                woken  = 1'b0;
                r.poll = 1'b1;
            end
            tlt_pkg::CMD_SAMPLE: begin
                sx = x;
                sy = y;
                ax = (sx < 0) ? -sx : sx;
                ay = (sy < 0) ? -sy : sy;
                th = int'(thr_unit) * (woken ? int'(tlt_pkg::FACTOR_WOKEN)
                                             : int'(tlt_pkg::FACTOR_IDLE));
                if (sx < -th && ax > ay) begin
                    cls = tlt_pkg::CLS_NEG_X;
                    key = key_neg_x;
                end else if (sx > th && ax > ay) begin
                    cls = tlt_pkg::CLS_POS_X;
                    key = key_pos_x;
                end else if (sy < -th && ay > ax) begin
                    cls = tlt_pkg::CLS_NEG_Y;
                    key = key_neg_y;
                end else if (sy > th && ay > ax) begin
                    cls = tlt_pkg::CLS_POS_Y;
                    key = key_pos_y;
                end
                if (cls == prev_class) begin
                    if (run_len != tlt_pkg::COUNT_MAX) run_len = run_len + 4'd1;
                end else begin
                    prev_class = cls;
                    run_len    = '0;
                end
                if (int'(run_len) >= MATCH_COUNT) begin
                    if (cls != tlt_pkg::CLS_NONE) begin
                        r.key_valid = 1'b1;
                        r.key_code  = key;
                        orient      = orientation_of(key);
                    end
                    r.done     = 1'b1;
                    r.cfg_word = tlt_pkg::CFG_BASE | {4'h0, tlt_pkg::DIR_ALL & ~cls};
                end else begin
                    if (sample_age != tlt_pkg::COUNT_MAX) sample_age = sample_age + 4'd1;
                    if (int'(sample_age) >= TIMEOUT_COUNT) begin
                        r.done     = 1'b1;
                        r.cfg_word = tlt_pkg::CFG_BASE | {4'h0, tlt_pkg::DIR_ALL};
                    end else begin
                        r.poll = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.tilt_class = cls;
        r.orientation = orient;
        tilt_reports_q.push_back(r);
    endtask

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        tilt_report_t want;
        if (!aresetn) begin
            restore_defaults();
            tilt_reports_q.delete();
            mismatch_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    tlt_pkg::REG_TILT_THRESHOLD: thr_unit  = cfg_wdata;
                    tlt_pkg::REG_KEY_NEG_X:      key_neg_x = cfg_wdata[1:0];
                    tlt_pkg::REG_KEY_POS_X:      key_pos_x = cfg_wdata[1:0];
                    tlt_pkg::REG_KEY_NEG_Y:      key_neg_y = cfg_wdata[1:0];
                    tlt_pkg::REG_KEY_POS_Y:      key_pos_y = cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                qualify_item(s_cmd, s_accel_x, s_accel_y);
            end
            if (m_valid && m_ready) begin
                if (tilt_reports_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result item arrived with none expected", $realtime);
                    end
                end else begin
                    want = tilt_reports_q.pop_front();
                    compare_field("tilt_class", want.tilt_class, m_tilt_class);
                    compare_field("key_valid", want.key_valid, m_key_valid);
                    compare_field("key_code", want.key_code, m_key_code);
                    compare_field("orientation_now", want.orientation, m_orientation_now);
                    compare_field("done_res", want.done, m_done_res);
                    compare_field("poll_again", want.poll, m_poll_again);
                    compare_field("int_config_word", want.cfg_word, m_int_config_word);
                end
            end
        end
        pending_count = tilt_reports_q.size();
    end

endmodule

@@ test/tb_tilt_orientation_qualifier_core.sv @@
`timescale 1ns / 1ps

module tb_tilt_orientation_qualifier_core;

    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [2:0] REG_SPARE   = 3'd7;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = tlt_pkg::REG_TILT_THRESHOLD;
    logic [6:0]         cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd = tlt_pkg::CMD_WAKE;
    logic signed [15:0] s_accel_x = '0;
    logic signed [15:0] s_accel_y = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [3:0]         m_tilt_class;
    logic               m_key_valid;
    logic [1:0]         m_key_code;
    logic [1:0]         m_orientation_now;
    logic               m_done_res;
    logic               m_poll_again;
    logic [7:0]         m_int_config_word;

    int mismatch_count;
    int pending_count;
    int cycle_count = 0;
    int stall_left = 0;
    bit quiet = 1'b0;
    int cur_thr = 7;
    bit woken_guess = 1'b0;

    always #1 aclk = ~aclk;

    tilt_orientation_qualifier_core uut (.*);

    tilt_orientation_qualifier_checker checker_i (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!quiet && aresetn && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [15:0] x,
                             input logic [15:0] y);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 12);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_accel_x <= x;
        s_accel_y <= y;
        do @(posedge aclk); while (!s_ready);
        if (cmd == tlt_pkg::CMD_WAKE) woken_guess = 1'b1;
        else if (cmd == tlt_pkg::CMD_RESTART) woken_guess = 1'b0;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [6:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        if (idx == tlt_pkg::REG_TILT_THRESHOLD) cur_thr = data;
    endtask

    task automatic configure(input int thr, input int key_mode);
        logic [6:0] data;
        logic [1:0] key;
        write_reg(tlt_pkg::REG_TILT_THRESHOLD, 7'(thr));
        for (int i = 0; i < 4; i++) begin
            case (key_mode)
                1:       key = tlt_pkg::KEY_NORTH;
                2:       key = tlt_pkg::KEY_WEST;
                default: key = 2'($urandom_range(0, 3));
            endcase
            data = 7'($urandom_range(0, 127));
            data[1:0] = key;
            write_reg(tlt_pkg::REG_KEY_NEG_X + 3'(i), data);
        end
        if ($urandom_range(0, 1) == 1) write_reg(REG_SPARE, 7'($urandom_range(0, 127)));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic make_sample(input int dir, output logic [15:0] x, output logic [15:0] y);
        int th, lim, dom, minor, major;
        th = cur_thr * (woken_guess ? 200 : 400);
        lim = (th > 32767) ? 32767 : th;
        if (dir == 0) begin
            case ($urandom_range(0, 2))
                0: begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                end
                1: begin
                    x = 16'($urandom_range(0, 1) ? lim : -lim);
                    y = 16'($urandom_range(0, lim));
                end
                default: begin
                    dom = $urandom_range(0, 32767);
                    x = 16'($urandom_range(0, 1) ? dom : -dom);
                    y = 16'($urandom_range(0, 1) ? dom : -dom);
                end
            endcase
        end else begin
            case ($urandom_range(0, 5))
                0:       dom = lim + 1;
                1:       dom = lim;
                2:       dom = 32767;
                default: dom = $urandom_range(lim + 1, 32767);
            endcase
            if (dom > 32767) dom = 32767;
            if (dom == 0) minor = 0;
            else if ($urandom_range(0, 5) == 0) minor = dom;
            else minor = $urandom_range(0, dom - 1);
            if ($urandom_range(0, 1) == 1) minor = -minor;
            major = (dir == 1 || dir == 3) ? -dom : dom;
            if (major == -32767 && $urandom_range(0, 1) == 1) major = -32768;
            if (dir <= 2) begin
                x = 16'(major);
                y = 16'(minor);
            end else begin
                x = 16'(minor);
                y = 16'(major);
            end
        end
    endtask

    task automatic run_random(input int count);
        int sent, dir, len;
        logic [15:0] x, y;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    send_item($urandom_range(0, 1) ? tlt_pkg::CMD_WAKE : tlt_pkg::CMD_RESTART,
                              16'($urandom), 16'($urandom));
                    sent++;
                end
                2: begin
                    send_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
                    sent++;
                end
                default: begin
                    dir = $urandom_range(0, 4);
                    len = $urandom_range(1, 20);
                    for (int k = 0; k < len; k++) begin
                        if ($urandom_range(0, 15) == 0) make_sample($urandom_range(0, 4), x, y);
                        else make_sample(dir, x, y);
                        send_item(tlt_pkg::CMD_SAMPLE, x, y);
                        sent++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        int thr;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(tlt_pkg::CMD_WAKE, 16'h0000, 16'h0000);
        send_item(tlt_pkg::CMD_SAMPLE, -16'sd32768, 16'sd5);
        send_item(tlt_pkg::CMD_SAMPLE, 16'sd32767, -16'sd32768);
        send_item(tlt_pkg::CMD_SAMPLE, 16'sd0, 16'sd32767);
        send_item(tlt_pkg::CMD_SAMPLE, 16'sd1400, 16'sd0);
        send_item(tlt_pkg::CMD_SAMPLE, 16'sd1401, -16'sd1401);
        repeat (7) send_item(tlt_pkg::CMD_SAMPLE, 16'sd1401, 16'sd0);
        send_item(2'd3, 16'hFFFF, 16'hFFFF);
        send_item(tlt_pkg::CMD_RESTART, 16'hFFFF, 16'h0000);
        send_item(tlt_pkg::CMD_SAMPLE, -16'sd2801, 16'sd100);
        send_item(tlt_pkg::CMD_SAMPLE, -16'sd2800, 16'sd100);
        send_item(tlt_pkg::CMD_SAMPLE, 16'sd0, -16'sd2801);
        send_item(tlt_pkg::CMD_SAMPLE, 16'sd0, 16'sd0);
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       thr = 0;
                1:       thr = 127;
                2:       thr = 1;
                default: thr = $urandom_range(0, 127);
            endcase
            configure(thr, p % 3);
            if (p == 5) quiet <= 1'b1;
            run_random((p == 1) ? 100 : 280);
            drain();
        end

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/tlt_pkg.sv
hdl/tlt_front.sv
hdl/tlt_queue.sv
hdl/tlt_back.sv
hdl/tilt_orientation_qualifier_core.sv
test/tilt_orientation_qualifier_checker.sv
test/tb_tilt_orientation_qualifier_core.sv
